>>> rtl/nlp_pkg.sv
package nlp_pkg;

  // Buffer geometry
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;

  // One input beat
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             out_last;
    logic             no_answer;
    logic             too_long;
  } out_item_t;

  // Buffer access request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SYM_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } buf_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_P_RD,
    S_P_CMP,
    S_S_RD,
    S_S_CMP,
    S_SW1,
    S_SW2,
    S_R_RD,
    S_R_W1,
    S_R_W2,
    S_E_RD,
    S_E_OUT,
    S_FLAG
  } state_t;

endpackage

>>> rtl/nlp_buf.sv
module nlp_buf (
  input  logic                      clk,
  input  nlp_pkg::buf_req_t         req,
  output logic [nlp_pkg::SYM_W-1:0] rd_a_q,
  output logic [nlp_pkg::SYM_W-1:0] rd_b_q
);

  logic [nlp_pkg::SYM_W-1:0] mem [nlp_pkg::MAX_LEN];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a_q <= mem[req.raddr_a];
    rd_b_q <= mem[req.raddr_b];
  end

endmodule

>>> rtl/nlp_seq.sv
module nlp_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  nlp_pkg::in_item_t         in_item,
  input  logic [nlp_pkg::SYM_W-1:0] rd_a_q,
  input  logic [nlp_pkg::SYM_W-1:0] rd_b_q,
  output nlp_pkg::buf_req_t         req,
  output logic                      busy,
  output logic                      out_strobe,
  output nlp_pkg::out_item_t        out_item
);

  localparam int AW = nlp_pkg::ADDR_W;
  localparam int CW = nlp_pkg::CNT_W;

  nlp_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]             fill_r, fill_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic                      na_r, na_nxt;
  logic                      tl_r, tl_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [AW-1:0]             p_r, p_nxt;
  logic [AW-1:0]             lo_r, lo_nxt;
  logic [AW-1:0]             hi_r, hi_nxt;
  logic [nlp_pkg::SYM_W-1:0] pval_r, pval_nxt;
  logic [nlp_pkg::SYM_W-1:0] sval_r, sval_nxt;
  logic [nlp_pkg::SYM_W-1:0] t_r, t_nxt;

  logic                      room;
  logic                      accept;
  logic [nlp_pkg::SYM_W-1:0] cmp_x;
  logic                      cmp_ge;
  logic [CW-1:0]             n_m1;

  assign busy   = (state_r != nlp_pkg::S_IDLE);
  assign accept = start && !busy;
  assign room   = (fill_r < CW'(nlp_pkg::MAX_LEN));
  assign n_m1   = n_r - CW'(1);

  // Shared byte comparator: pivot scan compares neighbours, successor scan
  // compares against the pivot value
  assign cmp_x  = (state_r == nlp_pkg::S_S_CMP) ? pval_r : rd_a_q;
  assign cmp_ge = (cmp_x >= rd_b_q);

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlp_pkg::S_IDLE;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
    n_r    <= n_nxt;
    na_r   <= na_nxt;
    tl_r   <= tl_nxt;
    idx_r  <= idx_nxt;
    p_r    <= p_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    pval_r <= pval_nxt;
    sval_r <= sval_nxt;
    t_r    <= t_nxt;
  end

  // Next state, buffer requests and result beats
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    na_nxt    = na_r;
    tl_nxt    = tl_r;
    idx_nxt   = idx_r;
    p_nxt     = p_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pval_nxt  = pval_r;
    sval_nxt  = sval_r;
    t_nxt     = t_r;

    req         = '0;
    out_strobe  = 1'b0;
    out_item    = '0;

    unique case (state_r)
      nlp_pkg::S_IDLE: begin
        if (accept) begin
          req.we    = room;
          req.waddr = fill_r[AW-1:0];
          req.wdata = in_item.symbol;
          if (in_item.last) begin
            n_nxt     = fill_r + CW'(room);
            tl_nxt    = ovf_r || !room;
            na_nxt    = 1'b0;
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = nlp_pkg::S_CHECK;
          end else if (room) begin
            fill_nxt = fill_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end

      nlp_pkg::S_CHECK: begin
        if (tl_r) begin
          state_nxt = nlp_pkg::S_FLAG;
        end else if (n_r < CW'(2)) begin
          na_nxt    = 1'b1;
          state_nxt = nlp_pkg::S_FLAG;
        end else begin
          idx_nxt   = n_m1[AW-1:0];
          state_nxt = nlp_pkg::S_P_RD;
        end
      end

      // Pivot scan, right to left
      nlp_pkg::S_P_RD: begin
        req.raddr_a = idx_r - AW'(1);
        req.raddr_b = idx_r;
        state_nxt   = nlp_pkg::S_P_CMP;
      end

      nlp_pkg::S_P_CMP: begin
        if (cmp_ge) begin
          if (idx_r == AW'(1)) begin
            na_nxt    = 1'b1;
            state_nxt = nlp_pkg::S_FLAG;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = nlp_pkg::S_P_RD;
          end
        end else begin
          p_nxt     = idx_r - AW'(1);
          pval_nxt  = rd_a_q;
          idx_nxt   = n_m1[AW-1:0];
          state_nxt = nlp_pkg::S_S_RD;
        end
      end

      // Successor scan: rightmost byte above the pivot
      nlp_pkg::S_S_RD: begin
        req.raddr_b = idx_r;
        state_nxt   = nlp_pkg::S_S_CMP;
      end

      nlp_pkg::S_S_CMP: begin
        if (cmp_ge) begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = nlp_pkg::S_S_RD;
        end else begin
          sval_nxt  = rd_b_q;
          state_nxt = nlp_pkg::S_SW1;
        end
      end

      // Swap pivot and successor
      nlp_pkg::S_SW1: begin
        req.we    = 1'b1;
        req.waddr = p_r;
        req.wdata = sval_r;
        state_nxt = nlp_pkg::S_SW2;
      end

      nlp_pkg::S_SW2: begin
        req.we    = 1'b1;
        req.waddr = idx_r;
        req.wdata = pval_r;
        hi_nxt    = n_m1[AW-1:0];
        if ((CW'(p_r) + CW'(1)) < n_m1) begin
          lo_nxt    = p_r + AW'(1);
          state_nxt = nlp_pkg::S_R_RD;
        end else begin
          lo_nxt    = '0;
          state_nxt = nlp_pkg::S_E_RD;
        end
      end

      // Suffix reversal: each pair is read, then written back in two write states
      nlp_pkg::S_R_RD: begin
        req.raddr_a = lo_r;
        req.raddr_b = hi_r;
        state_nxt   = nlp_pkg::S_R_W1;
      end

      nlp_pkg::S_R_W1: begin
        req.we    = 1'b1;
        req.waddr = lo_r;
        req.wdata = rd_b_q;
        t_nxt     = rd_a_q;
        state_nxt = nlp_pkg::S_R_W2;
      end

      nlp_pkg::S_R_W2: begin
        req.we    = 1'b1;
        req.waddr = hi_r;
        req.wdata = t_r;
        if ((CW'(lo_r) + CW'(1)) < (CW'(hi_r) - CW'(1))) begin
          lo_nxt    = lo_r + AW'(1);
          hi_nxt    = hi_r - AW'(1);
          state_nxt = nlp_pkg::S_R_RD;
        end else begin
          lo_nxt    = '0;
          state_nxt = nlp_pkg::S_E_RD;
        end
      end

      // Emit the permuted string
      nlp_pkg::S_E_RD: begin
        req.raddr_a = lo_r;
        state_nxt   = nlp_pkg::S_E_OUT;
      end

      nlp_pkg::S_E_OUT: begin
        out_strobe          = 1'b1;
        out_item.out_symbol = rd_a_q;
        out_item.out_last   = ((CW'(lo_r) + CW'(1)) == n_r);
        if (out_item.out_last) begin
          state_nxt = nlp_pkg::S_IDLE;
        end else begin
          lo_nxt    = lo_r + AW'(1);
          state_nxt = nlp_pkg::S_E_RD;
        end
      end

      nlp_pkg::S_FLAG: begin
        out_strobe         = 1'b1;
        out_item.out_last  = 1'b1;
        out_item.no_answer = na_r;
        out_item.too_long  = tl_r;
        state_nxt          = nlp_pkg::S_IDLE;
      end

      default: begin
        state_nxt = nlp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/next_lexicographic_permutation_unit.sv
// Loading: one byte per cycle, busy stays low until the byte flagged last.
// After the last byte, busy lasts while the sequencer scans, swaps, reverses and emits
// the n held bytes, paced by the sequencer's single compare unit and the buffer's
// one write port; a flag result is a single final beat.
// Each result byte is read from the buffer, then output; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer, fill count and overflow.
module next_lexicographic_permutation_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  nlp_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output nlp_pkg::out_item_t out_item
);

  nlp_pkg::buf_req_t         req;
  logic [nlp_pkg::SYM_W-1:0] rd_a_q;
  logic [nlp_pkg::SYM_W-1:0] rd_b_q;

  // String buffer
  nlp_buf u_buf (
    .clk    (clk),
    .req    (req),
    .rd_a_q (rd_a_q),
    .rd_b_q (rd_b_q)
  );

  // Sequencer and compare unit
  nlp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .rd_a_q     (rd_a_q),
    .rd_b_q     (rd_b_q),
    .req        (req),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef SYNTHESIS
  // Result beats only while a string is being worked on
  a_strobe_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat while idle");

  // Final beat of a run frees the block
  a_last_frees : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.out_last |=> !busy)
    else $error("still busy after final beat");

  // Flag results are single beats with one flag
  a_flag_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.no_answer || out_item.too_long) |->
      out_item.out_last && !(out_item.no_answer && out_item.too_long))
    else $error("malformed flag beat");

  // Last byte of a string starts processing
  a_last_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.last |=> busy)
    else $error("no processing after last byte");
`endif

endmodule
